[sv/i2cbb_pkg.sv]
// Shared package for the bit-banged I2C master: opcodes, pin commands and the
// command and status bundles that pass between controller and datapath.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package i2cbb_pkg;

   // Ack polls allowed before wait-ack gives up, and bits in one byte.
   localparam int ACK_POLL_LIMIT = 10;
   localparam int BYTE_BITS      = 8;

   // Reset value of the phase hold register.
   localparam logic [15:0] PHASE_TICKS_RESET = 16'd250;

   // Command opcodes as they arrive on the input channel.
   typedef enum logic [2:0] {
      OP_START     = 3'd0,
      OP_STOP      = 3'd1,
      OP_SEND_ACK  = 3'd2,
      OP_SEND_NACK = 3'd3,
      OP_WAIT_ACK  = 3'd4,
      OP_WRITE     = 3'd5,
      OP_READ      = 3'd6,
      OP_INVALID   = 3'd7
   } op_type;

   // What a phase does to a pin level.
   typedef enum logic [1:0] {
      PIN_KEEP = 2'd0,
      PIN_LOW  = 2'd1,
      PIN_HIGH = 2'd2,
      PIN_MSB  = 2'd3
   } pin_op_type;

   // What a phase does to the SDA direction.
   typedef enum logic [1:0] {
      DIR_KEEP    = 2'd0,
      DIR_DRIVE   = 2'd1,
      DIR_RELEASE = 2'd2
   } dir_op_type;

   // Controller to datapath: one phase worth of work.
   typedef struct packed {
      logic       capture;
      logic       emit;
      pin_op_type scl_op;
      pin_op_type sda_op;
      dir_op_type dir_op;
      logic       clear_shift;
      logic       shift_out;
      logic       shift_in;
      logic       poll_next;
      logic       last;
      logic       missing;
      logic       bad;
      logic       show_rv;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_free;
      logic hold_done;
      logic poll_high;
   } status_type;

endpackage

`default_nettype wire

[sv/i2cbb_datapath.sv]
// Datapath of the bit-banged I2C master: pin state, byte shifter, captured
// read and poll bits, phase hold timer, phase ticks register and result register.
// Depends on i2cbb_pkg; driven by i2cbb_ctrl through cmd_type.
`default_nettype none

module i2cbb_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire i2cbb_pkg::cmd_type   cmd,
   output i2cbb_pkg::status_type     status,
   input  wire logic                 csr_wr_en,
   input  wire logic [15:0]          csr_wr_data,
   input  wire logic [7:0]           req_write_data,
   input  wire logic [7:0]           req_line_read_bits,
   input  wire logic [9:0]           req_line_ack_polls,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic                      rsp_scl,
   output logic                      rsp_sda_level,
   output logic                      rsp_sda_driven,
   output logic                      rsp_last,
   output logic [7:0]                rsp_read_value,
   output logic                      rsp_ack_missing,
   output logic                      rsp_bad_command
);

   logic [15:0] phase_ticks_ff;
   logic [15:0] hold_timer_ff, hold_timer_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;
   logic        dir_ff, dir_in;
   logic [7:0]  shift_ff, shift_in_v;
   logic [7:0]  rbits_ff, rbits_in;
   logic [9:0]  polls_ff, polls_in;

   logic        rsp_valid_ff;
   logic        rsp_scl_ff, rsp_sda_level_ff, rsp_sda_driven_ff, rsp_last_ff;
   logic [7:0]  rsp_read_value_ff;
   logic        rsp_ack_missing_ff, rsp_bad_command_ff;

   // Status back to the controller.
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;
   assign status.hold_done = (hold_timer_ff <= 16'd1);
   assign status.poll_high = polls_ff[0];

   // Pin levels the current phase leaves on the bus.
   always_comb begin
      unique case (cmd.scl_op)
         i2cbb_pkg::PIN_LOW:  scl_in = 1'b0;
         i2cbb_pkg::PIN_HIGH: scl_in = 1'b1;
         i2cbb_pkg::PIN_MSB:  scl_in = shift_ff[7];
         default:             scl_in = scl_ff;
      endcase
      unique case (cmd.sda_op)
         i2cbb_pkg::PIN_LOW:  sda_in = 1'b0;
         i2cbb_pkg::PIN_HIGH: sda_in = 1'b1;
         i2cbb_pkg::PIN_MSB:  sda_in = shift_ff[7];
         default:             sda_in = sda_ff;
      endcase
      unique case (cmd.dir_op)
         i2cbb_pkg::DIR_DRIVE:   dir_in = 1'b1;
         i2cbb_pkg::DIR_RELEASE: dir_in = 1'b0;
         default:                dir_in = dir_ff;
      endcase
   end

   // Byte shifter, read sample and ack poll queues.
   always_comb begin
      shift_in_v = shift_ff;
      rbits_in   = rbits_ff;
      polls_in   = polls_ff;
      if (cmd.capture) begin
         shift_in_v = req_write_data;
         rbits_in   = req_line_read_bits;
         polls_in   = req_line_ack_polls;
      end else if (cmd.emit) begin
         if (cmd.clear_shift) begin
            shift_in_v = 8'd0;
         end else if (cmd.shift_in) begin
            shift_in_v = {shift_ff[6:0], rbits_ff[7]};
            rbits_in   = {rbits_ff[6:0], 1'b0};
         end else if (cmd.shift_out) begin
            shift_in_v = {shift_ff[6:0], 1'b0};
         end
         if (cmd.poll_next) begin
            polls_in = {1'b0, polls_ff[9:1]};
         end
      end
   end

   // Hold timer: reloaded on each emitted phase; a zero tick setting loads one.
   always_comb begin
      hold_timer_in = hold_timer_ff;
      if (cmd.emit) begin
         hold_timer_in = (phase_ticks_ff == 16'd0) ? 16'd1 : phase_ticks_ff;
      end else if (hold_timer_ff > 16'd1) begin
         hold_timer_in = hold_timer_ff - 16'd1;
      end
   end

   // Pin state, shifter, timer and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= i2cbb_pkg::PHASE_TICKS_RESET;
         hold_timer_ff  <= 16'd0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         dir_ff         <= 1'b1;
         shift_ff       <= 8'd0;
      end else begin
         if (csr_wr_en) begin
            phase_ticks_ff <= csr_wr_data;
         end
         hold_timer_ff <= hold_timer_in;
         shift_ff      <= shift_in_v;
         if (cmd.emit) begin
            scl_ff <= scl_in;
            sda_ff <= sda_in;
            dir_ff <= dir_in;
         end
      end
   end

   // Payload-only registers.
   always_ff @(posedge clock) begin
      rbits_ff <= rbits_in;
      polls_ff <= polls_in;
   end

   // Result register; one item per emitted phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_scl_ff         <= scl_in;
         rsp_sda_level_ff   <= dir_in & sda_in;
         rsp_sda_driven_ff  <= dir_in;
         rsp_last_ff        <= cmd.last;
         rsp_read_value_ff  <= cmd.show_rv ? shift_in_v : 8'd0;
         rsp_ack_missing_ff <= cmd.missing;
         rsp_bad_command_ff <= cmd.bad;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_scl         = rsp_scl_ff;
   assign rsp_sda_level   = rsp_sda_level_ff;
   assign rsp_sda_driven  = rsp_sda_driven_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_ack_missing = rsp_ack_missing_ff;
   assign rsp_bad_command = rsp_bad_command_ff;

   // A phase is only emitted when the result register can take it.
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("phase emitted while a stalled item is pending");

   // Every emitted phase loads a nonzero hold time.
   a_hold_loaded: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (hold_timer_ff != 16'd0))
      else $error("hold timer not loaded");

   // An invalid command leaves the pins as they were.
   a_bad_keeps_pins: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.bad) |=> ($stable(scl_ff) && $stable(sda_ff) && $stable(dir_ff)))
      else $error("invalid command changed the pins");

   // A released SDA is reported low.
   a_released_low: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_sda_driven_ff) |-> !rsp_sda_level_ff)
      else $error("released SDA reported high");

endmodule

`default_nettype wire

[sv/i2cbb_ctrl.sv]
// Controller of the bit-banged I2C master: takes commands, steps through the
// pin phases of each command and paces them with the datapath hold timer.
// Depends on i2cbb_pkg; drives i2cbb_datapath through cmd_type.
`default_nettype none

module i2cbb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [2:0]             req_opcode,
   input  wire i2cbb_pkg::status_type  status,
   output i2cbb_pkg::cmd_type          cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_HOLD,
      ST_DRAIN
   } state_type;

   state_type         state_ff, state_in;
   i2cbb_pkg::op_type op_ff, op_in;
   logic [4:0]        phase_ff, phase_in;
   logic [1:0]        sub_ff, sub_in;
   logic [2:0]        bit_ff, bit_in;
   logic              accept;
   logic              emit;
   logic              bit_final;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign emit      = (state_ff == ST_EMIT) && status.out_free;
   assign bit_final = (bit_ff == 3'(i2cbb_pkg::BYTE_BITS - 1));

   // Phase decode: what the current phase of the current command does.
   always_comb begin
      cmd             = '0;
      cmd.scl_op      = i2cbb_pkg::PIN_KEEP;
      cmd.sda_op      = i2cbb_pkg::PIN_KEEP;
      cmd.dir_op      = i2cbb_pkg::DIR_KEEP;
      cmd.capture     = accept;
      cmd.emit        = emit;
      unique case (op_ff) inside
         i2cbb_pkg::OP_START: begin
            unique case (phase_ff[1:0])
               2'd0: begin
                  cmd.dir_op = i2cbb_pkg::DIR_DRIVE;
                  cmd.sda_op = i2cbb_pkg::PIN_HIGH;
               end
               2'd1: begin
                  cmd.scl_op = i2cbb_pkg::PIN_HIGH;
                  cmd.sda_op = i2cbb_pkg::PIN_HIGH;
               end
               2'd2: begin
                  cmd.scl_op = i2cbb_pkg::PIN_HIGH;
                  cmd.sda_op = i2cbb_pkg::PIN_LOW;
               end
               default: begin
                  cmd.scl_op = i2cbb_pkg::PIN_LOW;
                  cmd.sda_op = i2cbb_pkg::PIN_LOW;
                  cmd.last   = 1'b1;
               end
            endcase
         end
         i2cbb_pkg::OP_STOP, i2cbb_pkg::OP_SEND_ACK, i2cbb_pkg::OP_SEND_NACK: begin
            unique case (phase_ff[1:0])
               2'd0: begin
                  cmd.dir_op = i2cbb_pkg::DIR_DRIVE;
                  cmd.scl_op = i2cbb_pkg::PIN_LOW;
               end
               2'd1: begin
                  cmd.scl_op = i2cbb_pkg::PIN_LOW;
                  cmd.sda_op = (op_ff == i2cbb_pkg::OP_SEND_NACK) ?
                               i2cbb_pkg::PIN_HIGH : i2cbb_pkg::PIN_LOW;
               end
               2'd2: begin
                  cmd.scl_op = i2cbb_pkg::PIN_HIGH;
                  cmd.sda_op = (op_ff == i2cbb_pkg::OP_SEND_NACK) ?
                               i2cbb_pkg::PIN_HIGH : i2cbb_pkg::PIN_LOW;
               end
               default: begin
                  // Stop releases the bus with both lines high.
                  cmd.scl_op = (op_ff == i2cbb_pkg::OP_STOP) ?
                               i2cbb_pkg::PIN_HIGH : i2cbb_pkg::PIN_LOW;
                  cmd.sda_op = (op_ff == i2cbb_pkg::OP_SEND_ACK) ?
                               i2cbb_pkg::PIN_LOW : i2cbb_pkg::PIN_HIGH;
                  cmd.last   = 1'b1;
               end
            endcase
         end
         i2cbb_pkg::OP_WAIT_ACK: begin
            if (phase_ff == 5'd0) begin
               cmd.dir_op = i2cbb_pkg::DIR_RELEASE;
            end else if (phase_ff == 5'd1) begin
               cmd.scl_op = i2cbb_pkg::PIN_LOW;
            end else if (phase_ff == 5'd2) begin
               cmd.scl_op = i2cbb_pkg::PIN_HIGH;
            end else if (!status.poll_high) begin
               // The slave pulled SDA low: ack seen.
               cmd.scl_op = i2cbb_pkg::PIN_LOW;
               cmd.last   = 1'b1;
            end else if (phase_ff >= 5'(i2cbb_pkg::ACK_POLL_LIMIT + 2)) begin
               // Poll limit reached without an ack.
               cmd.scl_op  = i2cbb_pkg::PIN_LOW;
               cmd.last    = 1'b1;
               cmd.missing = 1'b1;
            end else begin
               cmd.poll_next = 1'b1;
            end
         end
         i2cbb_pkg::OP_WRITE: begin
            if (phase_ff == 5'd0) begin
               cmd.dir_op = i2cbb_pkg::DIR_DRIVE;
            end else begin
               case (sub_ff)
                  2'd0:    cmd.sda_op = i2cbb_pkg::PIN_MSB;
                  2'd1:    cmd.scl_op = i2cbb_pkg::PIN_HIGH;
                  default: begin
                     cmd.scl_op    = i2cbb_pkg::PIN_LOW;
                     cmd.shift_out = 1'b1;
                     cmd.last      = bit_final;
                  end
               endcase
            end
         end
         i2cbb_pkg::OP_READ: begin
            if (phase_ff == 5'd0) begin
               cmd.dir_op      = i2cbb_pkg::DIR_RELEASE;
               cmd.clear_shift = 1'b1;
            end else if (sub_ff == 2'd0) begin
               cmd.scl_op = i2cbb_pkg::PIN_HIGH;
            end else begin
               cmd.scl_op   = i2cbb_pkg::PIN_LOW;
               cmd.shift_in = 1'b1;
               cmd.show_rv  = 1'b1;
               cmd.last     = bit_final;
            end
         end
         default: begin
            cmd.bad  = 1'b1;
            cmd.last = 1'b1;
         end
      endcase
   end

   // Next state and phase counters.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      phase_in = phase_ff;
      sub_in   = sub_ff;
      bit_in   = bit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EMIT;
               op_in    = i2cbb_pkg::op_type'(req_opcode);
               phase_in = 5'd0;
               sub_in   = 2'd0;
               bit_in   = 3'd0;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = cmd.last ? ST_DRAIN : ST_HOLD;
               phase_in = phase_ff + 5'd1;
               if (phase_ff != 5'd0) begin
                  if ((op_ff == i2cbb_pkg::OP_WRITE && sub_ff == 2'd2) ||
                      (op_ff == i2cbb_pkg::OP_READ && sub_ff == 2'd1)) begin
                     sub_in = 2'd0;
                     bit_in = bit_ff + 3'd1;
                  end else begin
                     sub_in = sub_ff + 2'd1;
                  end
               end
            end
         end
         ST_HOLD: begin
            if (status.hold_done) begin
               state_in = ST_EMIT;
            end
         end
         default: begin
            if (status.hold_done) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= i2cbb_pkg::OP_START;
         phase_ff <= 5'd0;
         sub_ff   <= 2'd0;
         bit_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         phase_ff <= phase_in;
         sub_ff   <= sub_in;
         bit_ff   <= bit_in;
      end
   end

   // An accepted command always leads straight into its first phase.
   a_accept_to_emit: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EMIT && phase_ff == 5'd0))
      else $error("accepted command did not start at its first phase");

   // No command runs longer than a write byte.
   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (phase_ff <= 5'd24))
      else $error("phase counter ran past the longest command");

   // The final phase of a command always ends in the drain hold.
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (emit && cmd.last) |=> (state_ff == ST_DRAIN))
      else $error("final phase did not end the command");

endmodule

`default_nettype wire

[sv/i2c_bitbang_master.sv]
// Top level of the bit-banged I2C master: joins controller and datapath.
// Depends on i2cbb_pkg, i2cbb_ctrl and i2cbb_datapath.
//
// One item on the req_ channel is one bus command (start, stop, send ack, send nack,
// wait ack, write byte, read byte); the block answers with one rsp_ item per pin
// phase, the final one marked by rsp_last. Each phase is held by the hold timer,
// loaded from the phase_ticks setting (a zero setting counts as one tick), and the
// next command is taken once the hold of the final phase has run out. A command
// takes 4 phases (start, stop, ack, nack), 4 to 13 (wait ack), 17 (read), 25
// (write) or 1 (invalid opcode); a stall on the result side holds a phase back.
// Read samples and ack polls are supplied with the command; rsp_ack_missing flags
// a wait ack that hit the poll limit.
`default_nettype none

module i2c_bitbang_master (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_write_data,
   input  wire logic [7:0]  req_line_read_bits,
   input  wire logic [9:0]  req_line_ack_polls,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_scl,
   output logic             rsp_sda_level,
   output logic             rsp_sda_driven,
   output logic             rsp_last,
   output logic [7:0]       rsp_read_value,
   output logic             rsp_ack_missing,
   output logic             rsp_bad_command
);

   i2cbb_pkg::cmd_type    cmd;
   i2cbb_pkg::status_type status;

   // Phase sequencer.
   i2cbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd)
   );

   // Pins, shifter, timer and result register.
   i2cbb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_write_data     (req_write_data),
      .req_line_read_bits (req_line_read_bits),
      .req_line_ack_polls (req_line_ack_polls),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_scl            (rsp_scl),
      .rsp_sda_level      (rsp_sda_level),
      .rsp_sda_driven     (rsp_sda_driven),
      .rsp_last           (rsp_last),
      .rsp_read_value     (rsp_read_value),
      .rsp_ack_missing    (rsp_ack_missing),
      .rsp_bad_command    (rsp_bad_command)
   );

endmodule

`default_nettype wire
